// ----- rtl/wave_elevation_synthesis_macros.svh -----
// ---------------------------------------------------------------------------
// Wave elevation synthesis assertion macros
// Concurrent assertion forms for the RTL of the block.
// ---------------------------------------------------------------------------
`ifndef WAVE_ELEVATION_SYNTHESIS_MACROS_SVH
`define WAVE_ELEVATION_SYNTHESIS_MACROS_SVH

// same-cycle implication, checked out of reset
`define WES_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wave elevation synthesis: assertion failed");

// next-cycle implication, checked out of reset
`define WES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wave elevation synthesis: assertion failed");

`endif

// ----- rtl/wes_pkg.sv -----
// ---------------------------------------------------------------------------
// Wave elevation synthesis package
// Payload types, job type, fixed constants, trig and saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package wes_pkg;

    typedef struct packed {
        logic               command;
        logic [7:0]         slot;
        logic [23:0]        amplitude;
        logic [27:0]        wavenumber;
        logic [27:0]        frequency;
        logic [15:0]        phase_offset;
        logic signed [31:0] x_position;
        logic [31:0]        sample_time;
        logic [8:0]         component_limit;
    } wes_in_t;

    typedef struct packed {
        logic signed [31:0] elevation;
        logic signed [31:0] slope_x;
    } wes_out_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } wes_op_t;

    // one classified transaction between front and back
    typedef struct packed {
        wes_op_t op;
        logic    slot_ok;
        wes_in_t item;
    } wes_job_t;

    localparam int ACC_W    = 60;
    localparam int ENTRY_W  = 96;
    localparam int LIMIT_W  = 13;
    localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

    function automatic logic [14:0] quarter_sine(input logic [6:0] r);
        logic [14:0] v;
        case (r)
            7'd0:  v = 15'd0;     7'd1:  v = 15'd804;   7'd2:  v = 15'd1608;
            7'd3:  v = 15'd2410;  7'd4:  v = 15'd3212;  7'd5:  v = 15'd4011;
            7'd6:  v = 15'd4808;  7'd7:  v = 15'd5602;  7'd8:  v = 15'd6393;
            7'd9:  v = 15'd7179;  7'd10: v = 15'd7962;  7'd11: v = 15'd8739;
            7'd12: v = 15'd9512;  7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
            7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13279;
            7'd18: v = 15'd14010; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
            7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
            7'd24: v = 15'd18204; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
            7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
            7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
            7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
            7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
            7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
            7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
            7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
            7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
            7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
            7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
            7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
            7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
            7'd63: v = 15'd32757; 7'd64: v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] coarse_sine(input logic [7:0] i);
        logic [6:0]  r;
        logic [14:0] q;
        r = {1'b0, i[5:0]};
        case (i[7:6])
            2'd0:    q = quarter_sine(r);
            2'd1:    q = quarter_sine(7'd64 - r);
            2'd2:    q = quarter_sine(r);
            default: q = quarter_sine(7'd64 - r);
        endcase
        if (i[7])
            return -$signed({1'b0, q});
        return $signed({1'b0, q});
    endfunction

    // sine of a 16-bit turn fraction, Q1.15, interpolated and rounded half up
    function automatic logic signed [15:0] fine_sine(input logic [15:0] p);
        logic signed [15:0] s0;
        logic signed [15:0] s1;
        logic signed [16:0] d;
        logic signed [26:0] t;
        s0 = coarse_sine(p[15:8]);
        s1 = coarse_sine(p[15:8] + 8'd1);
        d  = 17'(s1) - 17'(s0);
        t  = 27'(d) * $signed({19'd0, p[7:0]}) + 27'sd128;
        return s0 + 16'(t >>> 8);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wes_ram.sv -----
// ---------------------------------------------------------------------------
// Wave elevation synthesis RAM
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module wes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wes_front.sv -----
// ---------------------------------------------------------------------------
// Wave elevation synthesis front end
// Accept input transactions, classify them, and queue them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module wes_front #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire wes_pkg::wes_in_t  in_data,
    output logic                   job_valid,
    output wes_pkg::wes_job_t      job,
    input  wire logic              job_pop
);

    import wes_pkg::*;

    wes_job_t   q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    wes_job_t   classified;

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    // classify: load or evaluate, and whether a load lands inside the table
    always_comb
    begin
        classified.op      = in_data.command ? OP_EVAL : OP_LOAD;
        classified.slot_ok = (LIMIT_W'(in_data.slot) < LIMIT_W'(TABLE_DEPTH));
        classified.item    = in_data;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (job_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, job_pop};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wes_back.sv -----
// ---------------------------------------------------------------------------
// Wave elevation synthesis back end
// Execute loads and evaluations: component table, pipelined sum, final scale.
// ---------------------------------------------------------------------------
`default_nettype none

`include "wave_elevation_synthesis_macros.svh"

module wes_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [8:0]        active_components,
    input  wire logic              job_valid,
    input  wire wes_pkg::wes_job_t job,
    output logic                   job_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wes_pkg::wes_out_t      out_data
);

    import wes_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_ROUND,
        S_MUL,
        S_SUM
    } state_t;

    state_t state_reg;

    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      n_next;
    logic [LIMIT_W-1:0] count_w;
    logic [LIMIT_W-1:0] limit_w;
    logic signed [31:0] x_reg;
    logic [31:0]        t_reg;
    logic               issue;
    logic               load_wr;
    logic [ENTRY_W-1:0] rd_data;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [39:0]        kx1_reg, ft1_reg;
    logic [27:0]        ak1_reg;
    logic [23:0]        amp1_reg;
    logic [15:0]        phi1_reg;
    logic signed [60:0] kx_full;
    logic [59:0]        ft_full;
    logic [51:0]        ak_full;
    logic [23:0]        rd_amp;
    logic [27:0]        rd_k, rd_f;
    logic [15:0]        rd_phi;

    logic [39:0]        phase_sum;
    logic [15:0]        p2_reg;
    logic [23:0]        amp2_reg, amp3_reg;
    logic [27:0]        ak2_reg, ak3_reg;
    logic signed [15:0] c3_reg, s3_reg;
    logic signed [40:0] ec4_reg;
    logic signed [44:0] sk4_reg;

    logic signed [ACC_W-1:0] esum_reg, ssum_reg;
    logic signed [ACC_W-1:0] e_rnd, s_rnd;
    logic signed [31:0]      elev_reg;
    logic signed [34:0]      sclamp_reg;
    logic signed [34:0]      sclamp_next;
    logic signed [45:0]      ph_reg;
    logic [43:0]             pl_reg;
    logic signed [63:0]      prod;
    logic signed [63:0]      neg_rnd;
    logic                    out_free;
    wes_out_t                res_reg;
    logic                    res_valid_reg;

    // component count: active register held to table depth, then the item limit
    always_comb
    begin
        count_w = (LIMIT_W'(active_components) >= LIMIT_W'(TABLE_DEPTH))
                  ? LIMIT_W'(TABLE_DEPTH) : LIMIT_W'(active_components);
        limit_w = LIMIT_W'(job.item.component_limit);
        n_next  = ((limit_w == '0) || (limit_w >= count_w))
                  ? CW'(count_w) : CW'(limit_w);
    end

    assign job_pop = (state_reg == S_IDLE) && job_valid;
    assign load_wr = job_pop && (job.op == OP_LOAD) && job.slot_ok;
    assign issue   = (state_reg == S_RUN) && (idx_reg < n_reg);

    wes_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (load_wr),
        .wr_addr(AW'(job.item.slot)),
        .wr_data({job.item.amplitude, job.item.wavenumber,
                  job.item.frequency, job.item.phase_offset}),
        .rd_en  (issue),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    // datapath arithmetic per stage
    always_comb
    begin
        {rd_amp, rd_k, rd_f, rd_phi} = rd_data;
        kx_full   = $signed({1'b0, rd_k}) * x_reg;
        ft_full   = 60'(rd_f) * 60'(t_reg);
        ak_full   = 52'(rd_amp) * 52'(rd_k);
        phase_sum = kx1_reg - ft1_reg + {phi1_reg, 24'd0};
        e_rnd     = (esum_reg + ACC_W'(16384)) >>> 15;
        s_rnd     = (ssum_reg + ACC_W'(16384)) >>> 15;
        if (s_rnd > ACC_W'(64'sd8589934592))
            sclamp_next = 35'sd8589934592;
        else if (s_rnd < -ACC_W'(64'sd8589934592))
            sclamp_next = -35'sd8589934592;
        else
            sclamp_next = s_rnd[34:0];
        prod      = (64'(ph_reg) <<< 17) + $signed(64'(pl_reg));
        neg_rnd   = (-prod + 64'sd8388608) >>> 24;
        out_free  = !res_valid_reg || out_ready;
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (job_pop && (job.op == OP_EVAL))
        begin
            x_reg <= job.item.x_position;
            t_reg <= job.item.sample_time;
            n_reg <= n_next;
        end
        kx1_reg  <= kx_full[39:0];
        ft1_reg  <= ft_full[39:0];
        ak1_reg  <= ak_full[51:24];
        amp1_reg <= rd_amp;
        phi1_reg <= rd_phi;
        p2_reg   <= phase_sum[39:24];
        amp2_reg <= amp1_reg;
        ak2_reg  <= ak1_reg;
        c3_reg   <= fine_sine(p2_reg + 16'h4000);
        s3_reg   <= fine_sine(p2_reg);
        amp3_reg <= amp2_reg;
        ak3_reg  <= ak2_reg;
        ec4_reg  <= $signed({1'b0, amp3_reg}) * c3_reg;
        sk4_reg  <= $signed({1'b0, ak3_reg}) * s3_reg;
        if (state_reg == S_ROUND)
        begin
            elev_reg   <= sat32(64'(e_rnd));
            sclamp_reg <= sclamp_next;
        end
        if (state_reg == S_MUL)
        begin
            ph_reg <= $signed(sclamp_reg[34:17]) * $signed({1'b0, TWO_PI_Q24});
            pl_reg <= 44'(sclamp_reg[16:0]) * 44'(TWO_PI_Q24);
        end
        if ((state_reg == S_SUM) && out_free)
        begin
            res_reg.elevation <= elev_reg;
            res_reg.slope_x   <= sat32(neg_rnd);
        end
    end

    // control: state, index, stage valids, sums and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            esum_reg      <= '0;
            ssum_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if ((state_reg == S_SUM) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_pop && (job.op == OP_EVAL))
                    begin
                        idx_reg   <= '0;
                        esum_reg  <= '0;
                        ssum_reg  <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (v5_reg)
                    begin
                        esum_reg <= esum_reg + ACC_W'(ec4_reg);
                        ssum_reg <= ssum_reg + ACC_W'(sk4_reg);
                    end
                    if (!issue && !v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    `WES_ASSERT_NOW(a_acc_only_running, v5_reg, state_reg == S_RUN)
    `WES_ASSERT_NOW(a_pop_only_idle, job_pop, state_reg == S_IDLE)
    `WES_ASSERT_NOW(a_idx_bounded, state_reg == S_RUN, idx_reg <= n_reg)
    `WES_ASSERT_NEXT(a_result_follows_sum, (state_reg == S_SUM) && out_free,
                     res_valid_reg && (state_reg == S_IDLE))

endmodule

`default_nettype wire

// ----- rtl/wave_elevation_synthesis.sv -----
// ---------------------------------------------------------------------------
// Wave elevation synthesis
// Sum-of-sinusoids sea surface: elevation and x-slope from a component table.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  cfg     | in        | cfg_valid/cfg_ready | cfg_data, active_components
//  in      | in        | in_valid/in_ready   | wes_in_t, load or evaluate
//  out     | out       | out_valid/out_ready | wes_out_t, per evaluate
//
//  A load transaction writes the table as it leaves the queue, and the back end
//  stays idle. An evaluation makes one table read per cycle, for each of its n
//  components, through the single read port into a five-stage phase, trig and
//  multiply pipeline feeding the accumulators, then passes the ROUND, MUL and
//  SUM states for rounding and 2*pi scaling before presenting its result.
//  Reset clears control state and active_components; table contents stay
//  undefined until loaded. A two-entry queue accepts input, until full, while
//  the back end works; the output register holds a result under back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module wave_elevation_synthesis #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [8:0]       cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire wes_pkg::wes_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wes_pkg::wes_out_t     out_data
);

    import wes_pkg::*;

    logic       [8:0] active_reg;
    logic             job_valid;
    logic             job_pop;
    wes_job_t         job;

    // configuration writes land at any time; the user only writes while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 9'd0;
        end
        else if (cfg_valid)
        begin
            active_reg <= cfg_data;
        end
    end

    // front: accept and classify each transaction, hold it in the queue
    wes_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop)
    );

    // back: table writes, the evaluation pipeline and the output register
    wes_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .active_components(active_reg),
        .job_valid        (job_valid),
        .job              (job),
        .job_pop          (job_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data)
    );

endmodule

`default_nettype wire
